// ===== hdl/bfba_pkg.sv =====
// Shared constants for the best-fit block allocator.
package bfba_pkg;

    // Default sizing of the free-size table
    localparam int BLOCKS_DEF    = 16;
    localparam int SIZE_BITS_DEF = 16;

    // Fixed port field widths
    localparam int CFG_W   = 5;
    localparam int IDX_W   = 4;
    localparam int FIELD_W = 16;

    // Item opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    // Reset value of the blocks-in-use register
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

// ===== hdl/bfba_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    i_clk,
    i_we,
    i_waddr,
    i_wdata,
    i_raddr,
    o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    input  logic             i_clk;
    input  logic             i_we;
    input  logic [AW-1:0]    i_waddr;
    input  logic [WIDTH-1:0] i_wdata;
    input  logic [AW-1:0]    i_raddr;
    output logic [WIDTH-1:0] o_rdata;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/best_fit_block_allocator.sv =====
// Best-fit block allocator: free-size table with a sequential best-fit scan.
// Load: written straight into the table if the index is in range, no result, busy stays low.
// Allocate: one table read per cycle over N = min(blocks_in_use, BLOCKS) entries, then
//   a one-cycle result strobe; busy is high from the accepting edge until the strobe.
// A new item is taken only while busy is low; the receiver cannot stall.
// Sync active-low reset clears the sequencer and sets blocks_in_use to 16; table undefined.
module best_fit_block_allocator #(
    parameter int BLOCKS    = bfba_pkg::BLOCKS_DEF,
    parameter int SIZE_BITS = bfba_pkg::SIZE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bfba_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic                         i_opcode,
    input  logic [bfba_pkg::IDX_W-1:0]   i_block_index,
    input  logic [bfba_pkg::FIELD_W-1:0] i_size_value,
    output logic                         o_valid,
    output logic                         o_granted,
    output logic [bfba_pkg::IDX_W-1:0]   o_chosen_block,
    output logic [bfba_pkg::FIELD_W-1:0] o_size_left
);
    import bfba_pkg::*;

    localparam int AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int SW = SIZE_BITS;
    localparam int CW = 9;   // holds any index or count up to 256
    localparam int XW = 32;  // holds any size value

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [CFG_W-1:0]   r_limit, n_limit;
    logic [CFG_W-1:0]   r_addr, n_addr;
    logic               r_pend, n_pend;
    logic [AW-1:0]      r_pidx, n_pidx;
    logic               r_found, n_found;
    logic [AW-1:0]      r_best, n_best;
    logic [SW-1:0]      r_best_val, n_best_val;
    logic [SW-1:0]      r_req, n_req;
    logic               r_valid, n_valid;
    logic               r_granted, n_granted;
    logic [IDX_W-1:0]   r_chosen, n_chosen;
    logic [FIELD_W-1:0] r_left, n_left;

    logic               accept;
    logic               in_range;
    logic [CW-1:0]      idx_ext;
    logic [CW-1:0]      sat_limit;
    logic               issue;
    logic [SW-1:0]      req_in;
    logic [SW-1:0]      new_val;
    logic [XW-1:0]      new_val_ext;
    logic [CW-1:0]      best_ext;
    logic [CW-1:0]      addr_ext;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [SW-1:0]      ram_wdata;
    logic [SW-1:0]      ram_rdata;
    logic [XW-1:0]      size_ext;

    assign accept    = i_start && (r_state == ST_IDLE);
    assign idx_ext   = CW'(i_block_index);
    assign in_range  = idx_ext < CW'(BLOCKS);
    assign sat_limit = (CW'(r_cfg) > CW'(BLOCKS)) ? CW'(BLOCKS) : CW'(r_cfg);
    assign size_ext  = XW'(i_size_value);
    assign req_in    = size_ext[SW-1:0];
    assign issue     = r_addr < r_limit;
    assign addr_ext  = CW'(r_addr);
    assign best_ext  = CW'(r_best);
    assign new_val   = r_best_val - r_req;
    assign new_val_ext = XW'(new_val);

    // table write port: loads from the input, charges from the done step
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_ext[AW-1:0];
        ram_wdata = req_in;
        if (accept && (i_opcode == OP_LOAD) && in_range) begin
            ram_we = 1'b1;
        end else if ((r_state == ST_DONE) && r_found) begin
            ram_we    = 1'b1;
            ram_waddr = r_best;
            ram_wdata = new_val;
        end
    end

    bfba_ram #(
        .WIDTH (SW),
        .DEPTH (BLOCKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (addr_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // sequencer: scan one entry per cycle, compare each entry in the cycle after its read
    always_comb begin
        n_state    = r_state;
        n_limit    = r_limit;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_found    = r_found;
        n_best     = r_best;
        n_best_val = r_best_val;
        n_req      = r_req;
        n_valid    = 1'b0;
        n_granted  = r_granted;
        n_chosen   = r_chosen;
        n_left     = r_left;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_opcode == OP_ALLOC)) begin
                    n_state = ST_SCAN;
                    n_limit = sat_limit[CFG_W-1:0];
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    n_req   = req_in;
                end
            end
            ST_SCAN: begin
                // compare the entry read last cycle
                if (r_pend && (ram_rdata >= r_req) &&
                    (!r_found || (ram_rdata < r_best_val))) begin
                    n_found    = 1'b1;
                    n_best     = r_pidx;
                    n_best_val = ram_rdata;
                end
                n_pend = issue;
                n_pidx = addr_ext[AW-1:0];
                if (issue) begin
                    n_addr = r_addr + 1'b1;
                end else if (!r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state   = ST_IDLE;
                n_valid   = 1'b1;
                n_granted = r_found;
                n_chosen  = r_found ? best_ext[IDX_W-1:0] : '0;
                n_left    = r_found ? new_val_ext[FIELD_W-1:0] : '0;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cfg   <= CFG_RESET;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_limit    <= n_limit;
        r_addr     <= n_addr;
        r_pidx     <= n_pidx;
        r_best     <= n_best;
        r_best_val <= n_best_val;
        r_req      <= n_req;
        r_granted  <= n_granted;
        r_chosen   <= n_chosen;
        r_left     <= n_left;
    end

    assign o_busy         = r_state != ST_IDLE;
    assign o_valid        = r_valid;
    assign o_granted      = r_granted;
    assign o_chosen_block = r_chosen;
    assign o_size_left    = r_left;

endmodule

// ===== hdl/bfba_checker.sv =====
// Port-level checks for the best-fit block allocator, bound to the top level.
module bfba_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_start,
    input logic                         o_busy,
    input logic                         i_opcode,
    input logic                         o_valid,
    input logic                         o_granted,
    input logic [bfba_pkg::IDX_W-1:0]   o_chosen_block,
    input logic [bfba_pkg::FIELD_W-1:0] o_size_left
);
    import bfba_pkg::*;

    // a refused request reports all-zero fields
    a_nogrant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_granted) |-> (o_chosen_block == '0) && (o_size_left == '0))
        else $error("no-grant result carries nonzero fields");

    // an allocate item occupies the block on the next cycle
    a_alloc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_opcode == OP_ALLOC)) |=> o_busy)
        else $error("allocate accepted but block not busy");

    // a load item finishes at once and produces no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_opcode == OP_LOAD)) |=> (!o_busy && !o_valid))
        else $error("load item caused busy or a result");

    // a result is a single-cycle strobe shown after the scan ends
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_busy && $past(o_busy)))
        else $error("result strobe outside end of scan");

endmodule

bind best_fit_block_allocator bfba_checker u_bfba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .i_opcode       (i_opcode),
    .o_valid        (o_valid),
    .o_granted      (o_granted),
    .o_chosen_block (o_chosen_block),
    .o_size_left    (o_size_left)
);
